[sv/lsf_pkg.sv]
// Shared types and constants for the scan-line edge/plane feature selector.
package lsf_pkg;

  localparam int COORD_W   = 17;
  localparam int IDX_W     = 11;
  localparam int LBL_W     = 3;
  localparam int CURV_W    = 42;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 4;

  localparam logic [LBL_W-1:0] LBL_LESS_FLAT  = 3'd0;
  localparam logic [LBL_W-1:0] LBL_FLAT       = 3'd1;
  localparam logic [LBL_W-1:0] LBL_LESS_SHARP = 3'd2;
  localparam logic [LBL_W-1:0] LBL_SHARP      = 3'd3;
  localparam logic [LBL_W-1:0] LBL_NONE       = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CURV_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LESS_SHARP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAT       = 3'd4;

  localparam logic [CURV_W-1:0] CURV_MAX       = {CURV_W{1'b1}};
  localparam logic [CURV_W-1:0] RST_CURV_THR   = 42'd6554;
  localparam logic [CURV_W-1:0] RST_GAP_THR    = 42'd3277;
  localparam logic [CNT_W-1:0]  RST_SHARP      = 6'd2;
  localparam logic [CNT_W-1:0]  RST_LESS_SHARP = 6'd20;
  localparam logic [CNT_W-1:0]  RST_FLAT       = 6'd4;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    cmd_t             cmd;
    logic             last;
    point_t           pt;
    logic [IDX_W-1:0] ri;
  } item_t;

  typedef struct packed {
    logic [CURV_W-1:0] curv_thr;
    logic [CURV_W-1:0] gap_thr;
    logic [CNT_W-1:0]  sharp;
    logic [CNT_W-1:0]  less_sharp;
    logic [CNT_W-1:0]  flat;
  } cfg_t;

endpackage

[sv/lidar_scan_edge_plane_feature_select.sv]
// Top level of the scan-line edge/plane feature selector.
// Flow: a load request is taken from the queue by the engine once the engine is idle; a read
//   request passes through the queue and S_RDWAIT to a registered result when the engine is free.
// Throughput: one load per cycle while the engine is idle and the queue is not full; processing
//   after the last point is bounded by the single point-store read port and the shared
//   squaring unit.
// Reset clears control state only; stores are not swept, labels read as not classified.
module lidar_scan_edge_plane_feature_select #(
  parameter int MAX_POINTS  = 2048,
  parameter int SECTORS     = 6,
  parameter int HALF_WINDOW = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic signed [16:0] x_pos,
  input  logic signed [16:0] y_pos,
  input  logic signed [16:0] z_pos,
  input  logic               last_point,
  input  logic [10:0]        read_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        point_index,
  output logic [2:0]         feature_label,
  output logic [41:0]        curvature_value,
  output logic               index_error,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [41:0]        cfg_data
);
  import lsf_pkg::*;

  // configuration registers; the user must write them only while the block is idle (not enforced here)
  cfg_t  cfg;

  // front end to queue, queue to engine
  logic  q_push, q_pop, q_full, q_empty;
  item_t q_item, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.curv_thr   <= RST_CURV_THR;
      cfg.gap_thr    <= RST_GAP_THR;
      cfg.sharp      <= RST_SHARP;
      cfg.less_sharp <= RST_LESS_SHARP;
      cfg.flat       <= RST_FLAT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CURV_THR:   cfg.curv_thr   <= cfg_data;
        CFG_GAP_THR:    cfg.gap_thr    <= cfg_data;
        CFG_SHARP:      cfg.sharp      <= cfg_data[CNT_W-1:0];
        CFG_LESS_SHARP: cfg.less_sharp <= cfg_data[CNT_W-1:0];
        CFG_FLAT:       cfg.flat       <= cfg_data[CNT_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // accept and decode requests; stall only when the queue is full
  lsf_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .z_pos      (z_pos),
    .last_point (last_point),
    .read_index (read_index),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  // hold requests while the engine walks a processed line
  lsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // stores, curvature, sector ranking, suppression and the output register
  lsf_engine #(
    .MAX_POINTS  (MAX_POINTS),
    .SECTORS     (SECTORS),
    .HALF_WINDOW (HALF_WINDOW)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .head            (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .point_index     (point_index),
    .feature_label   (feature_label),
    .curvature_value (curvature_value),
    .index_error     (index_error)
  );

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push) else $error("push into full queue");

  // the engine never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_pop) else $error("pop from empty queue");

  // an index error reports an unclassified point with zero curvature
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> feature_label == LBL_NONE && curvature_value == '0)
    else $error("bad index result");

  // unclassified points carry no curvature
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && feature_label == LBL_NONE |-> curvature_value == '0)
    else $error("curvature on unclassified point");

endmodule

[sv/lsf_front.sv]
// Front end: takes requests off the input channel and decodes them for the queue.
module lsf_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic signed [16:0]          x_pos,
  input  logic signed [16:0]          y_pos,
  input  logic signed [16:0]          z_pos,
  input  logic                        last_point,
  input  logic [10:0]                 read_index,
  input  logic                        q_full,
  output logic                        q_push,
  output lsf_pkg::item_t              q_item
);
  import lsf_pkg::*;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.cmd  = opcode ? CMD_READ : CMD_LOAD;
    // a last flag only means something on a load
    q_item.last = !opcode && last_point;
    q_item.pt.x = x_pos;
    q_item.pt.y = y_pos;
    q_item.pt.z = z_pos;
    q_item.ri   = read_index;
  end

endmodule

[sv/lsf_queue.sv]
// Short request queue between the front end and the engine.
module lsf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lsf_pkg::item_t push_item,
  input  logic           pop,
  output lsf_pkg::item_t head,
  output logic           full,
  output logic           empty
);
  import lsf_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  item_t             slots [Q_DEPTH];
  logic [PW-1:0]     wp;
  logic [PW-1:0]     rp;
  logic [PW:0]       count;

  assign full  = count == (PW+1)'(Q_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

[sv/lsf_engine.sv]
// Back end: point stores, curvature, sector picking, suppression and label reads.
module lsf_engine #(
  parameter int MAX_POINTS  = 2048,
  parameter int SECTORS     = 6,
  parameter int HALF_WINDOW = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  lsf_pkg::cfg_t      cfg,
  input  lsf_pkg::item_t     head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        point_index,
  output logic [2:0]         feature_label,
  output logic [41:0]        curvature_value,
  output logic               index_error
);
  import lsf_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = AW + 1;
  localparam int WIN   = 2 * HALF_WINDOW + 1;
  localparam int WW    = $clog2(WIN);
  localparam int LW    = $clog2(HALF_WINDOW + 1);
  localparam int JW    = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int DW    = COORD_W + 1 + $clog2(WIN);
  localparam int PW    = 2 * DW;
  localparam int ACW   = PW + 2;
  localparam int MIN_N = WIN + SECTORS;

  typedef enum logic [18:0] {
    S_IDLE   = 19'b1 << 0,
    S_RDWAIT = 19'b1 << 1,
    S_CLR    = 19'b1 << 2,
    S_CVRD   = 19'b1 << 3,
    S_CVWAIT = 19'b1 << 4,
    S_CVD    = 19'b1 << 5,
    S_SQ     = 19'b1 << 6,
    S_CVWR   = 19'b1 << 7,
    S_BADD   = 19'b1 << 8,
    S_BDIV   = 19'b1 << 9,
    S_LBL    = 19'b1 << 10,
    S_SCRD   = 19'b1 << 11,
    S_SCWAIT = 19'b1 << 12,
    S_SCEND  = 19'b1 << 13,
    S_SUC0   = 19'b1 << 14,
    S_SUC1   = 19'b1 << 15,
    S_SUNX   = 19'b1 << 16,
    S_SUW    = 19'b1 << 17,
    S_SUCHK  = 19'b1 << 18
  } state_t;

  // stores
  point_t            pmem [MAX_POINTS];
  logic [CURV_W-1:0] cmem [MAX_POINTS];
  logic              fmem [MAX_POINTS];
  logic [LBL_W-1:0]  lmem [MAX_POINTS];

  point_t            pm_rdata;
  logic [CURV_W-1:0] cm_rdata;
  logic              fm_rdata;
  logic [LBL_W-1:0]  lm_rdata;

  logic              pm_we, cm_we, fm_we, lm_we, fm_wdata;
  logic [AW-1:0]     pm_waddr, pm_raddr, cm_raddr, fm_waddr, lm_waddr, lm_raddr;
  logic [CURV_W-1:0] cm_wdata;
  logic [LBL_W-1:0]  lm_wdata;

  state_t            state, ret_state;
  logic [CW-1:0]     cnt_pts;
  logic              line_done;
  logic [CW-1:0]     k;
  logic [WW-1:0]     w, rd_w;
  logic              rd_v;
  logic signed [DW-1:0] sx, sy, sz;
  point_t            center, prev, cur;
  logic signed [DW-1:0] d0, d1, d2;
  logic [1:0]        sq_cnt;
  logic [PW-1:0]     prod;
  logic [ACW-1:0]    acc;
  logic [JW-1:0]     j;
  logic [CW-1:0]     q, bs, s_lo, s_hi;
  logic [CW:0]       r;
  logic              flat_mode, found, sc_v, dir;
  logic [CNT_W:0]    pcnt;
  logic [AW-1:0]     best_idx, sc_k, sa;
  logic [CURV_W-1:0] best_c;
  logic [LW-1:0]     l;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_err;

  // combinational helpers
  logic [CW-1:0]     eff_cnt, hi, span, win_addr, a_right, a_left, a_sel;
  logic              load_ok, side_out, gap_stop, corner_stop, cand, better;
  logic [CNT_W:0]    pcnt_next;
  logic signed [DW-1:0] dsel;
  logic [DW-1:0]     mag;
  logic [PW-1:0]     sq;
  logic [LBL_W-1:0]  lbl_rd;

  assign eff_cnt   = line_done ? '0 : cnt_pts;
  assign load_ok   = eff_cnt < CW'(MAX_POINTS);
  assign hi        = cnt_pts - CW'(HALF_WINDOW + 1);
  assign span      = cnt_pts - CW'(WIN);
  assign win_addr  = k - CW'(HALF_WINDOW) + CW'(w);
  assign a_right   = CW'(best_idx) + CW'(l);
  assign a_left    = CW'(best_idx) - CW'(l);
  assign a_sel     = dir ? a_right : a_left;
  assign side_out  = dir ? (a_right >= cnt_pts) : (CW'(l) > CW'(best_idx));
  assign gap_stop  = acc > ACW'(cfg.gap_thr);
  assign pcnt_next = pcnt + 1'b1;
  assign corner_stop = !found || (pcnt_next > {1'b0, cfg.sharp} &&
                                  pcnt_next > {1'b0, cfg.less_sharp});
  assign cand   = !fm_rdata && (flat_mode ? (cm_rdata < cfg.curv_thr)
                                          : (cm_rdata > cfg.curv_thr));
  // ascending scan: ties keep the lower index for flat, the higher for corners
  assign better = !found || (flat_mode ? (cm_rdata < best_c) : (cm_rdata >= best_c));
  assign dsel   = (sq_cnt == 2'd0) ? d0 : (sq_cnt == 2'd1) ? d1 : d2;
  assign mag    = dsel[DW-1] ? $unsigned(-dsel) : $unsigned(dsel);
  assign sq     = PW'(mag) * PW'(mag);
  assign lbl_rd = line_done ? lm_rdata : LBL_NONE;

  always_comb begin
    q_pop    = 1'b0;
    pm_we    = 1'b0;
    pm_waddr = eff_cnt[AW-1:0];
    pm_raddr = k[AW-1:0];
    cm_we    = 1'b0;
    cm_raddr = k[AW-1:0];
    cm_wdata = (acc > ACW'(CURV_MAX)) ? CURV_MAX : acc[CURV_W-1:0];
    fm_we    = 1'b0;
    fm_waddr = k[AW-1:0];
    fm_wdata = 1'b0;
    lm_we    = 1'b0;
    lm_waddr = k[AW-1:0];
    lm_wdata = LBL_NONE;
    lm_raddr = AW'(head.ri);
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          if (head.cmd == CMD_LOAD) begin
            q_pop = 1'b1;
            pm_we = load_ok;
          end else if (!out_valid) begin
            q_pop    = 1'b1;
            cm_raddr = AW'(head.ri);
          end
        end
      end
      S_CLR: begin
        fm_we = 1'b1;
        lm_we = 1'b1;
      end
      S_CVRD: pm_raddr = win_addr[AW-1:0];
      S_CVWR: cm_we = 1'b1;
      S_LBL: begin
        lm_we    = 1'b1;
        lm_wdata = LBL_LESS_FLAT;
      end
      S_SCEND: begin
        lm_waddr = best_idx;
        if (flat_mode) begin
          lm_we    = found;
          lm_wdata = LBL_FLAT;
        end else begin
          lm_we    = !corner_stop;
          lm_wdata = (pcnt_next <= {1'b0, cfg.sharp}) ? LBL_SHARP : LBL_LESS_SHARP;
        end
      end
      S_SUC0: begin
        fm_we    = 1'b1;
        fm_waddr = best_idx;
        fm_wdata = 1'b1;
        pm_raddr = best_idx;
      end
      S_SUNX: pm_raddr = a_sel[AW-1:0];
      S_SUCHK: begin
        fm_we    = !gap_stop;
        fm_waddr = sa;
        fm_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_waddr] <= head.pt;
    pm_rdata <= pmem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) cmem[k[AW-1:0]] <= cm_wdata;
    cm_rdata <= cmem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (fm_we) fmem[fm_waddr] <= fm_wdata;
    fm_rdata <= fmem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (lm_we) lmem[lm_waddr] <= lm_wdata;
    lm_rdata <= lmem[lm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt_pts   <= '0;
      line_done <= 1'b0;
      out_valid <= 1'b0;
      rd_v      <= 1'b0;
      sc_v      <= 1'b0;
    end else begin
      rd_v <= (state == S_CVRD);
      sc_v <= (state == S_SCRD);
      rd_w <= w;
      sc_k <= k[AW-1:0];
      if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (head.cmd == CMD_LOAD) begin
              line_done <= 1'b0;
              cnt_pts   <= eff_cnt + CW'(load_ok);
              if (head.last) begin
                k     <= '0;
                state <= S_CLR;
              end
            end else if (!out_valid) begin
              rd_idx <= head.ri;
              rd_err <= 32'(head.ri) >= 32'(cnt_pts);
              state  <= S_RDWAIT;
            end
          end
        end
        S_RDWAIT: begin
          out_valid     <= 1'b1;
          point_index   <= rd_idx;
          index_error   <= rd_err;
          feature_label <= rd_err ? LBL_NONE : lbl_rd;
          curvature_value <= (rd_err || lbl_rd == LBL_NONE) ? '0 : cm_rdata;
          state         <= S_IDLE;
        end
        S_CLR: begin
          if (k + 1'b1 == cnt_pts) begin
            if (cnt_pts < CW'(MIN_N)) begin
              line_done <= 1'b1;
              state     <= S_IDLE;
            end else begin
              k     <= CW'(HALF_WINDOW);
              w     <= '0;
              state <= S_CVRD;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_CVRD: begin
          w <= w + 1'b1;
          if (w == WW'(WIN - 1)) state <= S_CVWAIT;
        end
        S_CVWAIT: state <= S_CVD;
        S_CVD: begin
          d0        <= sx - (DW'(center.x) * DW'(WIN));
          d1        <= sy - (DW'(center.y) * DW'(WIN));
          d2        <= sz - (DW'(center.z) * DW'(WIN));
          sq_cnt    <= '0;
          ret_state <= S_CVWR;
          state     <= S_SQ;
        end
        S_SQ: begin
          prod   <= sq;
          acc    <= (sq_cnt == 2'd0) ? '0 : acc + ACW'(prod);
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 2'd3) state <= ret_state;
        end
        S_CVWR: begin
          if (k == hi) begin
            j     <= '0;
            q     <= '0;
            r     <= '0;
            bs    <= '0;
            state <= S_BADD;
          end else begin
            k     <= k + 1'b1;
            w     <= '0;
            state <= S_CVRD;
          end
        end
        S_BADD: begin
          r     <= r + (CW+1)'(span);
          state <= S_BDIV;
        end
        S_BDIV: begin
          if (r >= (CW+1)'(SECTORS)) begin
            r <= r - (CW+1)'(SECTORS);
            q <= q + 1'b1;
          end else if (q == bs) begin
            if (j == JW'(SECTORS - 1)) begin
              line_done <= 1'b1;
              state     <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= S_BADD;
            end
          end else begin
            s_lo  <= CW'(HALF_WINDOW) + bs;
            s_hi  <= CW'(HALF_WINDOW) + q - 1'b1;
            k     <= CW'(HALF_WINDOW) + bs;
            state <= S_LBL;
          end
        end
        S_LBL: begin
          if (k == s_hi) begin
            pcnt      <= '0;
            flat_mode <= 1'b0;
            found     <= 1'b0;
            k         <= s_lo;
            state     <= S_SCRD;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_SCRD: begin
          if (k == s_hi) state <= S_SCWAIT;
          else           k     <= k + 1'b1;
        end
        S_SCWAIT: state <= S_SCEND;
        S_SCEND: begin
          if (!flat_mode) begin
            if (corner_stop) begin
              flat_mode <= 1'b1;
              pcnt      <= '0;
              found     <= 1'b0;
              k         <= s_lo;
              state     <= S_SCRD;
            end else begin
              pcnt  <= pcnt_next;
              state <= S_SUC0;
            end
          end else if (!found || pcnt_next >= {1'b0, cfg.flat}) begin
            // sector finished
            bs <= q;
            if (j == JW'(SECTORS - 1)) begin
              line_done <= 1'b1;
              state     <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= S_BADD;
            end
          end else begin
            pcnt  <= pcnt_next;
            state <= S_SUC0;
          end
        end
        S_SUC0: begin
          dir   <= 1'b1;
          l     <= LW'(1);
          state <= S_SUC1;
        end
        S_SUC1: begin
          center <= pm_rdata;
          prev   <= pm_rdata;
          state  <= S_SUNX;
        end
        S_SUNX: begin
          if (side_out) begin
            if (dir) begin
              dir  <= 1'b0;
              l    <= LW'(1);
              prev <= center;
            end else begin
              found <= 1'b0;
              k     <= s_lo;
              state <= S_SCRD;
            end
          end else begin
            sa    <= a_sel[AW-1:0];
            state <= S_SUW;
          end
        end
        S_SUW: begin
          cur       <= pm_rdata;
          d0        <= DW'(pm_rdata.x) - DW'(prev.x);
          d1        <= DW'(pm_rdata.y) - DW'(prev.y);
          d2        <= DW'(pm_rdata.z) - DW'(prev.z);
          sq_cnt    <= '0;
          ret_state <= S_SUCHK;
          state     <= S_SQ;
        end
        S_SUCHK: begin
          if (gap_stop || l == LW'(HALF_WINDOW)) begin
            if (dir) begin
              dir   <= 1'b0;
              l     <= LW'(1);
              prev  <= center;
              state <= S_SUNX;
            end else begin
              found <= 1'b0;
              k     <= s_lo;
              state <= S_SCRD;
            end
          end else begin
            prev  <= cur;
            l     <= l + 1'b1;
            state <= S_SUNX;
          end
        end
        default: state <= S_IDLE;
      endcase

      // window sums for the curvature of point k
      if (state == S_CVRD && w == '0) begin
        sx <= '0;
        sy <= '0;
        sz <= '0;
      end else if (rd_v) begin
        sx <= sx + DW'(pm_rdata.x);
        sy <= sy + DW'(pm_rdata.y);
        sz <= sz + DW'(pm_rdata.z);
      end
      if (rd_v && rd_w == WW'(HALF_WINDOW)) center <= pm_rdata;

      // sector scan: keep the best candidate seen so far
      if (sc_v && cand && better) begin
        found    <= 1'b1;
        best_idx <= sc_k;
        best_c   <= cm_rdata;
      end
    end
  end

endmodule

[tb/lidar_scan_edge_plane_feature_select_test.sv]
// Self-checking testbench for the scan-line edge/plane feature selector.
module lidar_scan_edge_plane_feature_select_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lsf_pkg::*;

  localparam int NPTS      = 2048;
  localparam int NSECT     = 6;
  localparam int HW        = 5;
  localparam int RAND_REQS = 800;
  localparam int LIMIT     = 4000000;

  // One expected read response.
  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [LBL_W-1:0]  lbl;
    logic [CURV_W-1:0] curv;
    logic              err;
  } label_rsp_t;

  // One row of the directed table. Rows marked fixed carry their answer;
  // all typed answers have a zero curvature.
  typedef struct packed {
    cmd_t                      op;
    logic                      last;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [IDX_W-1:0]          ri;
    logic                      fixed;
    logic [LBL_W-1:0]          lbl;
    logic                      err;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = 1'b0;
  logic signed [16:0] x_pos = '0;
  logic signed [16:0] y_pos = '0;
  logic signed [16:0] z_pos = '0;
  logic last_point = 1'b0;
  logic [10:0] read_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [10:0] point_index;
  logic [2:0] feature_label;
  logic [41:0] curvature_value;
  logic index_error;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [41:0] cfg_data = '0;

  lidar_scan_edge_plane_feature_select DUT (.*);

  always #5 clk = ~clk;

  // Predictor state: its own copy of the stores and the registers.
  point_t            line_pts [NPTS];
  logic [CURV_W-1:0] line_curv [NPTS];
  int                sector_rank [NPTS];
  bit                taken [NPTS];
  logic [LBL_W-1:0]  point_lbl [NPTS];
  int                loaded;
  bit                line_closed;
  cfg_t              regs;

  label_rsp_t label_rsp_q[$];
  int  mismatches = 0;
  int  reads_checked = 0;
  int  reqs_sent = 0;
  int  lines_done = 0;
  int  cfg_phases = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;     // no idling on either side while set
  int  out_stall = 0;

  dir_row_t dir_rows [20] = '{
    '{CMD_READ, 1'b0, 17'sd0, 17'sd0, 17'sd0, 11'd0,    1'b1, LBL_NONE, 1'b1},
    '{CMD_READ, 1'b1, 17'sd0, 17'sd0, 17'sd0, 11'd2047, 1'b1, LBL_NONE, 1'b1},
    '{CMD_LOAD, 1'b0, -17'sd65536, 17'sd65535, 17'sd0, 11'd0, 1'b0, LBL_NONE, 1'b0},
    '{CMD_LOAD, 1'b0, 17'sd65535, -17'sd65536, -17'sd1, 11'd0, 1'b0, LBL_NONE, 1'b0},
    '{CMD_LOAD, 1'b0, -17'sd65536, -17'sd65536, -17'sd65536, 11'd0, 1'b0, LBL_NONE, 1'b0},
    '{CMD_LOAD, 1'b0, 17'sd65535, 17'sd65535, 17'sd65535, 11'd0, 1'b0, LBL_NONE, 1'b0},
    '{CMD_LOAD, 1'b0, 17'sd0, 17'sd0, 17'sd0, 11'd0, 1'b0, LBL_NONE, 1'b0},
    '{CMD_LOAD, 1'b0, -17'sd1, -17'sd1, -17'sd1, 11'd0, 1'b0, LBL_NONE, 1'b0},
    '{CMD_LOAD, 1'b0, 17'sd65535, 17'sd0, -17'sd65536, 11'd0, 1'b0, LBL_NONE, 1'b0},
    '{CMD_LOAD, 1'b0, -17'sd65536, 17'sd0, 17'sd65535, 11'd0, 1'b0, LBL_NONE, 1'b0},
    '{CMD_LOAD, 1'b0, 17'sd256, 17'sd512, -17'sd768, 11'd0, 1'b0, LBL_NONE, 1'b0},
    '{CMD_LOAD, 1'b0, 17'sd65535, 17'sd65535, -17'sd65536, 11'd0, 1'b0, LBL_NONE, 1'b0},
    '{CMD_LOAD, 1'b0, -17'sd65536, -17'sd65536, 17'sd65535, 11'd0, 1'b0, LBL_NONE, 1'b0},
    '{CMD_LOAD, 1'b1, 17'sd1, 17'sd2, 17'sd3, 11'd0, 1'b0, LBL_NONE, 1'b0},
    // twelve points: too short to classify, every label stays unclassified
    '{CMD_READ, 1'b0, 17'sd0, 17'sd0, 17'sd0, 11'd3,  1'b1, LBL_NONE, 1'b0},
    '{CMD_READ, 1'b0, 17'sd0, 17'sd0, 17'sd0, 11'd11, 1'b1, LBL_NONE, 1'b0},
    '{CMD_READ, 1'b0, 17'sd0, 17'sd0, 17'sd0, 11'd12, 1'b1, LBL_NONE, 1'b1},
    // a load after a finished line opens a new one
    '{CMD_LOAD, 1'b0, 17'sd0, 17'sd0, 17'sd0, 11'd2047, 1'b0, LBL_NONE, 1'b0},
    '{CMD_READ, 1'b0, 17'sd0, 17'sd0, 17'sd0, 11'd0, 1'b1, LBL_NONE, 1'b0},
    '{CMD_READ, 1'b0, 17'sd0, 17'sd0, 17'sd0, 11'd1, 1'b1, LBL_NONE, 1'b1}
  };

  // ---------------------------------------------------------------- predictor

  function automatic longint coord(int i, int c);
    case (c)
      0: return longint'(line_pts[i].x);
      1: return longint'(line_pts[i].y);
      default: return longint'(line_pts[i].z);
    endcase
  endfunction

  function automatic longint unsigned sq(longint d);
    longint unsigned m;
    m = (d < 0) ? longint'(-d) : d;
    return m * m;
  endfunction

  function automatic longint unsigned step_dist(int a, int b);
    longint unsigned s;
    s = 0;
    for (int c = 0; c < 3; c++) s += sq(coord(a, c) - coord(b, c));
    return s;
  endfunction

  // Mark a pick and its neighbors until a step wider than the gap threshold.
  function automatic void mark_neighbors(int idx, int n);
    int a;
    taken[idx] = 1'b1;
    for (int l = 1; l <= HW; l++) begin
      a = idx + l;
      if (a >= n || step_dist(a, a - 1) > regs.gap_thr) break;
      taken[a] = 1'b1;
    end
    for (int l = 1; l <= HW; l++) begin
      a = idx - l;
      if (a < 0 || step_dist(a, a + 1) > regs.gap_thr) break;
      taken[a] = 1'b1;
    end
  endfunction

  function automatic void classify_line();
    int n, lo, hi, span, s, e, m, v, idx, cnt;
    longint d;
    longint unsigned acc;
    n = loaded;
    lo = HW;
    hi = n - 1 - HW;
    for (int k = 0; k < NPTS; k++) taken[k] = 1'b0;
    if (hi < lo) return;
    for (int i = lo; i <= hi; i++) begin
      acc = 0;
      for (int c = 0; c < 3; c++) begin
        d = 0;
        for (int w = -HW; w <= HW; w++) d += coord(i + w, c);
        d -= (2 * HW + 1) * coord(i, c);
        acc += sq(d);
      end
      line_curv[i] = (acc > CURV_MAX) ? CURV_MAX : acc[CURV_W-1:0];
    end
    if (hi - lo < NSECT) return;
    span = hi - lo;
    for (int j = 0; j < NSECT; j++) begin
      s = lo + span * j / NSECT;
      e = lo + span * (j + 1) / NSECT - 1;
      if (e < s) continue;
      for (int k = s; k <= e; k++) begin
        point_lbl[k] = LBL_LESS_FLAT;
        sector_rank[k] = k;
      end
      // stable ascending order by curvature
      for (int k = s + 1; k <= e; k++) begin
        v = sector_rank[k];
        m = k;
        while (m > s && line_curv[sector_rank[m - 1]] > line_curv[v]) begin
          sector_rank[m] = sector_rank[m - 1];
          m--;
        end
        sector_rank[m] = v;
      end
      cnt = 0;
      for (int k = e; k >= s; k--) begin
        idx = sector_rank[k];
        if (taken[idx] || line_curv[idx] <= regs.curv_thr) continue;
        cnt++;
        if (cnt <= regs.sharp) point_lbl[idx] = LBL_SHARP;
        else if (cnt <= regs.less_sharp) point_lbl[idx] = LBL_LESS_SHARP;
        else break;
        mark_neighbors(idx, n);
      end
      cnt = 0;
      for (int k = s; k <= e; k++) begin
        idx = sector_rank[k];
        if (taken[idx] || line_curv[idx] >= regs.curv_thr) continue;
        point_lbl[idx] = LBL_FLAT;
        cnt++;
        if (cnt >= regs.flat) break;
        mark_neighbors(idx, n);
      end
    end
  endfunction

  function automatic void predict_load(point_t p, logic last);
    if (line_closed) begin
      loaded = 0;
      for (int k = 0; k < NPTS; k++) point_lbl[k] = LBL_NONE;
      line_closed = 1'b0;
    end
    if (loaded < NPTS) begin
      line_pts[loaded] = p;
      loaded++;
    end
    if (last) begin
      classify_line();
      line_closed = 1'b1;
      lines_done++;
    end
  endfunction

  function automatic label_rsp_t predict_read(logic [IDX_W-1:0] ri);
    label_rsp_t r;
    r.idx = ri;
    r.lbl = LBL_NONE;
    r.curv = '0;
    r.err = 1'b0;
    if (ri >= loaded) r.err = 1'b1;
    else begin
      r.lbl = point_lbl[ri];
      if (r.lbl != LBL_NONE) r.curv = line_curv[ri];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Send one request: idle a random gap, hold it until taken, then predict.
  task automatic send_req(cmd_t op, logic last, point_t p, logic [IDX_W-1:0] ri,
                          bit fixed, logic [LBL_W-1:0] lbl, logic err);
    int gap;
    label_rsp_t r;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode = op;
    last_point = last;
    x_pos = p.x;
    y_pos = p.y;
    z_pos = p.z;
    read_index = ri;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    reqs_sent++;
    if (op == CMD_LOAD) predict_load(p, last);
    else begin
      r = predict_read(ri);
      if (fixed) begin
        r.lbl = lbl;
        r.err = err;
        r.curv = '0;
      end
      label_rsp_q.insert(label_rsp_q.size(), r);
    end
    @(negedge clk);
  endtask

  task automatic read_point(int ri);
    point_t p;
    p = '0;
    send_req(CMD_READ, 1'($urandom_range(0, 1)), p, ri[IDX_W-1:0], 1'b0, LBL_NONE, 1'b0);
  endtask

  // Drain: a read only returns once the engine is free, so its answer
  // proves the block idle.
  task automatic settle();
    read_point($urandom_range(0, 2047));
    in_valid = 1'b0;
    while (label_rsp_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CURV_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      CFG_CURV_THR:   regs.curv_thr = val;
      CFG_GAP_THR:    regs.gap_thr = val;
      CFG_SHARP:      regs.sharp = val[CNT_W-1:0];
      CFG_LESS_SHARP: regs.less_sharp = val[CNT_W-1:0];
      CFG_FLAT:       regs.flat = val[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [CURV_W-1:0] pick_thr(int phase, logic [CURV_W-1:0] dflt);
    if (phase == 0) return CURV_MAX;
    if (phase == 1) return '0;
    case ($urandom_range(0, 5))
      0: return dflt;
      1: return 42'($urandom_range(0, 100));
      2: return 42'($urandom_range(0, 1 << 20));
      3: return 42'($urandom) << 8;
      4: return CURV_MAX;
      default: return 42'($urandom_range(1000, 200000));
    endcase
  endfunction

  function automatic logic [CURV_W-1:0] pick_count(int phase, logic [CNT_W-1:0] dflt);
    if (phase == 0) return 42'd63;
    if (phase == 1) return '0;
    case ($urandom_range(0, 4))
      0: return 42'(dflt);
      1: return 42'($urandom_range(0, 3));
      2: return 42'd63;
      default: return 42'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic new_phase(int phase);
    settle();
    write_reg(CFG_CURV_THR, pick_thr(phase, RST_CURV_THR));
    write_reg(CFG_GAP_THR, pick_thr(phase, RST_GAP_THR));
    write_reg(CFG_SHARP, pick_count(phase, RST_SHARP));
    write_reg(CFG_LESS_SHARP, pick_count(phase, RST_LESS_SHARP));
    write_reg(CFG_FLAT, pick_count(phase, RST_FLAT));
    cfg_phases++;
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic signed [COORD_W-1:0] clamp(longint v);
    if (v > 65535) return 17'sd65535;
    if (v < -65536) return -17'sd65536;
    return v[COORD_W-1:0];
  endfunction

  // One scan line: a smooth walk with occasional jumps and wild points,
  // a few reads mixed in while loading, then a burst of reads.
  task automatic scan_line(int n, int nreads);
    longint cx, cy, cz, stp;
    point_t p;
    cx = $signed($urandom_range(0, 131071)) - 65536;
    cy = $signed($urandom_range(0, 131071)) - 65536;
    cz = $signed($urandom_range(0, 8191)) - 4096;
    case ($urandom_range(0, 2))
      0: stp = 4;
      1: stp = 40;
      default: stp = 400;
    endcase
    for (int i = 0; i < n; i++) begin
      cx += $signed($urandom_range(0, 2 * stp)) - stp;
      cy += $signed($urandom_range(0, 2 * stp)) - stp;
      cz += $signed($urandom_range(0, stp)) - stp / 2;
      if ($urandom_range(0, 19) == 0) cx += $signed($urandom_range(0, 40000)) - 20000;
      p.x = clamp(cx);
      p.y = clamp(cy);
      p.z = clamp(cz);
      if ($urandom_range(0, 39) == 0) p = point_t'({$urandom, $urandom});
      send_req(CMD_LOAD, (i == n - 1), p, 11'($urandom), 1'b0, LBL_NONE, 1'b0);
      if ($urandom_range(0, 29) == 0) read_point($urandom_range(0, i + 2));
    end
    for (int r = 0; r < nreads; r++) begin
      if ($urandom_range(0, 15) == 0) read_point(2047);
      else read_point($urandom_range(0, n + 2));
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    label_rsp_t r;
    if (!rst && out_valid && out_ready) begin
      if (label_rsp_q.size() == 0) begin
        report("unexpected response, index", point_index, 0);
      end else begin
        r = label_rsp_q.pop_front();
        reads_checked++;
        if (point_index !== r.idx) report("point_index", point_index, r.idx);
        if (feature_label !== r.lbl) report("feature_label", feature_label, r.lbl);
        if (curvature_value !== r.curv) report("curvature_value", curvature_value, r.curv);
        if (index_error !== r.err) report("index_error", index_error, r.err);
      end
    end
  end

  // Receiver: draw a stall after every taken response unless quiet is set.
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (out_valid && out_ready && !quiet) out_stall <= $urandom_range(0, 10);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int phase, n;
    regs = '{RST_CURV_THR, RST_GAP_THR, RST_SHARP, RST_LESS_SHARP, RST_FLAT};
    loaded = 0;
    line_closed = 1'b0;
    for (int k = 0; k < NPTS; k++) point_lbl[k] = LBL_NONE;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_req(dir_rows[i].op, dir_rows[i].last,
               '{dir_rows[i].x, dir_rows[i].y, dir_rows[i].z},
               dir_rows[i].ri, dir_rows[i].fixed, dir_rows[i].lbl, dir_rows[i].err);

    // Smallest classifiable line under reset settings, then random phases.
    scan_line(17, 18);
    phase = 0;
    while (reqs_sent < RAND_REQS) begin
      new_phase(phase);
      for (int l = 0; l < 2; l++) begin
        case ($urandom_range(0, 5))
          0: n = $urandom_range(11, 17);
          1: n = $urandom_range(150, 220);
          default: n = $urandom_range(17, 60);
        endcase
        scan_line(n, $urandom_range(6, 14));
      end
      phase++;
    end

    in_valid = 1'b0;
    while (label_rsp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d requests over %0d scan lines and %0d register settings;",
             reqs_sent, lines_done, cfg_phases);
    $display("checked %0d label reads, %0d mismatches.", reads_checked, mismatches);
    if (mismatches == 0 && label_rsp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
